@@ hdl/stq_pkg.sv @@
// ---------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Status, request, time mode and keep mode codes, cell operations and the cell structs.
// ---------------------------------------------------------------------------
package stq_pkg;

  localparam int QueueDepthDef = 16;
  localparam int TimeBitsDef   = 32;
  localparam int MaxResults    = 16;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_BAD_TIME = 3'd1;
  localparam logic [2:0] ST_KEPT     = 3'd2;
  localparam logic [2:0] ST_BAD_KEEP = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_FIRED    = 3'd5;
  localparam logic [2:0] ST_NONE     = 3'd6;

  localparam logic FUNC_REGISTER = 1'b0;
  localparam logic FUNC_TICK     = 1'b1;

  localparam logic [1:0] TM_ABSOLUTE = 2'd1;
  localparam logic [1:0] TM_RELATIVE = 2'd2;

  localparam logic [1:0] KM_NONE     = 2'd0;
  localparam logic [1:0] KM_EARLIEST = 2'd1;
  localparam logic [1:0] KM_LATEST   = 2'd2;
  localparam logic [1:0] KM_INVALID  = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_INSERT = 2'd2,
    OP_POP    = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [1:0] keep_mode;
  } cell_ctrl_t;

  typedef struct packed {
    logic le;     // valid and stored deadline at or before the key
    logic found;  // an owner match here or in some cell to the left
    logic kept;   // first owner match, and the policy keeps it
  } cell_stat_t;

endpackage

@@ hdl/sorted_timer_queue_top.sv @@
// ---------------------------------------------------------------------------
// sorted_timer_queue_top: timer queue kept sorted by deadline
// Registers timers with a keep policy and fires due entries on a tick, at most 16.
// ---------------------------------------------------------------------------
//
// Channel   Handshake          Payload
// request   start / busy       func, deadline, time_mode, keep_mode, owner_id, now
// result    valid (strobe)     status, fired_owner, fired_deadline, last
//
// A register request passes through deadline computation, owner search and
// removal, and insertion; without a keep policy it skips the search, and a
// rejected mode ends it after the deadline computation. A tick fires the due
// entries one result at a time, at most 16, or gives one ST_NONE result when
// nothing is due. Every step moves the whole row of cells at once, so no step
// depends on the queue's fill. Reset empties the queue at once; busy is low after reset.
// Results cannot be stalled: each is shown for one cycle with valid high.
module sorted_timer_queue_top #(
  parameter int QUEUE_DEPTH = stq_pkg::QueueDepthDef,
  parameter int TIME_BITS   = stq_pkg::TimeBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [31:0] deadline,
  input  logic [1:0]  time_mode,
  input  logic [1:0]  keep_mode,
  input  logic [7:0]  owner_id,
  input  logic [31:0] now,
  output logic        valid,
  output logic [2:0]  status,
  output logic [7:0]  fired_owner,
  output logic [31:0] fired_deadline,
  output logic        last
);
  import stq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = $clog2(MaxResults + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CALC = 5'b00010,
    S_KEEP = 5'b00100,
    S_INS  = 5'b01000,
    S_TICK = 5'b10000
  } state_t;

  state_t state;

  // Request captured at the transfer, both times cut or zero-extended to TIME_BITS.
  logic [TIME_BITS-1:0] req_dl;
  logic [1:0]           req_tmode;
  logic [1:0]           req_kmode;
  logic [7:0]           req_owner;
  logic [TIME_BITS-1:0] req_now;
  logic [TIME_BITS-1:0] dl_in, now_in, fired_dl_full;

  logic [CW-1:0] count;
  logic [NW-1:0] fired_n;

  generate
    if (TIME_BITS >= 32) begin : g_wide
      assign dl_in  = TIME_BITS'(deadline);
      assign now_in = TIME_BITS'(now);
    end else begin : g_narrow
      assign dl_in  = deadline[TIME_BITS-1:0];
      assign now_in = now[TIME_BITS-1:0];
    end
  endgenerate

  // Relative deadlines saturate at the largest time value.
  logic [TIME_BITS:0] rel_sum;
  assign rel_sum = {1'b0, req_now} + {1'b0, req_dl};

  // The row of cells. The key is the new deadline, or now during a tick.
  cell_ctrl_t           ctrl;
  logic [TIME_BITS-1:0] key;
  logic [TIME_BITS-1:0] c_dl  [QUEUE_DEPTH];
  logic [7:0]           c_own [QUEUE_DEPTH];
  cell_stat_t           c_stat[QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] kept_v;

  assign key = (state == S_TICK) ? req_now : req_dl;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 l_le, f_in;
    logic [TIME_BITS-1:0] l_dl, r_dl;
    logic [7:0]           l_own, r_own;

    if (i == 0) begin : g_first
      assign l_le  = 1'b1;
      assign f_in  = 1'b0;
      assign l_dl  = '0;
      assign l_own = '0;
    end else begin : g_mid
      assign l_le  = c_stat[i-1].le;
      assign f_in  = c_stat[i-1].found;
      assign l_dl  = c_dl[i-1];
      assign l_own = c_own[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign r_dl  = '0;
      assign r_own = '0;
    end else begin : g_inner
      assign r_dl  = c_dl[i+1];
      assign r_own = c_own[i+1];
    end

    stq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .entry_valid   (count > CW'(i)),
      .key           (key),
      .key_owner     (req_owner),
      .left_le       (l_le),
      .found_in      (f_in),
      .left_deadline (l_dl),
      .left_owner    (l_own),
      .right_deadline(r_dl),
      .right_owner   (r_own),
      .cell_deadline (c_dl[i]),
      .cell_owner    (c_own[i]),
      .stat          (c_stat[i])
    );
    assign kept_v[i] = c_stat[i].kept;
  end

  // Tick decisions look only at the head and the entry behind it.
  logic head_due, next_due, tick_last;
  assign head_due = c_stat[0].le;
  generate
    if (QUEUE_DEPTH > 1) begin : g_next
      assign next_due = c_stat[1].le;
    end else begin : g_single
      assign next_due = 1'b0;
    end
  endgenerate
  assign tick_last = !next_due || (fired_n == NW'(MaxResults - 1));

  always_comb begin
    ctrl.keep_mode = req_kmode;
    ctrl.op        = OP_HOLD;
    unique case (state)
      S_KEEP: begin
        if (c_stat[QUEUE_DEPTH-1].found && (kept_v == '0)) begin
          ctrl.op = OP_REMOVE;
        end
      end
      S_INS: begin
        if (count < CW'(QUEUE_DEPTH)) begin
          ctrl.op = OP_INSERT;
        end
      end
      S_TICK: begin
        if (head_due) begin
          ctrl.op = OP_POP;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  generate
    if (TIME_BITS >= 32) begin : g_out_wide
      assign fired_deadline = fired_dl_full[31:0];
    end else begin : g_out_narrow
      assign fired_deadline = {{(32-TIME_BITS){1'b0}}, fired_dl_full};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      fired_n <= '0;
      valid   <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_dl    <= dl_in;
            req_tmode <= time_mode;
            req_kmode <= keep_mode;
            req_owner <= owner_id;
            req_now   <= now_in;
            fired_n   <= '0;
            state     <= (func == FUNC_TICK) ? S_TICK : S_CALC;
          end
        end
        S_CALC: begin
          if (req_tmode == TM_RELATIVE) begin
            req_dl <= rel_sum[TIME_BITS] ? '1 : rel_sum[TIME_BITS-1:0];
          end
          if (req_tmode != TM_RELATIVE && req_tmode != TM_ABSOLUTE) begin
            valid  <= 1'b1;
            status <= ST_BAD_TIME;
            state  <= S_IDLE;
          end else if (req_kmode == KM_INVALID) begin
            valid  <= 1'b1;
            status <= ST_BAD_KEEP;
            state  <= S_IDLE;
          end else if (req_kmode == KM_NONE) begin
            state <= S_INS;
          end else begin
            state <= S_KEEP;
          end
        end
        S_KEEP: begin
          if (kept_v != '0) begin
            valid  <= 1'b1;
            status <= ST_KEPT;
            state  <= S_IDLE;
          end else begin
            if (ctrl.op == OP_REMOVE) begin
              count <= count - 1'b1;
            end
            state <= S_INS;
          end
        end
        S_INS: begin
          valid <= 1'b1;
          if (ctrl.op == OP_INSERT) begin
            status <= ST_INSERTED;
            count  <= count + 1'b1;
          end else begin
            status <= ST_FULL;
          end
          state <= S_IDLE;
        end
        S_TICK: begin
          valid <= 1'b1;
          if (head_due) begin
            status  <= ST_FIRED;
            count   <= count - 1'b1;
            fired_n <= fired_n + 1'b1;
            if (tick_last) begin
              state <= S_IDLE;
            end
          end else begin
            status <= ST_NONE;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result payload; non-fired results carry zero owner and deadline.
  always_ff @(posedge clk) begin
    if (state == S_TICK && head_due) begin
      fired_owner   <= c_own[0];
      fired_dl_full <= c_dl[0];
      last          <= tick_last;
    end else begin
      fired_owner   <= '0;
      fired_dl_full <= '0;
      last          <= 1'b1;
    end
  end

endmodule

@@ hdl/stq_cell.sv @@
// ---------------------------------------------------------------------------
// stq_cell: one slot of the sorted queue
// Holds one entry, compares it with the key and moves data to or from its
// neighbors on insert, remove and pop.
// ---------------------------------------------------------------------------
module stq_cell #(
  parameter int TIME_BITS = stq_pkg::TimeBitsDef
) (
  input  logic                 clk,
  input  stq_pkg::cell_ctrl_t  ctrl,
  input  logic                 entry_valid,
  input  logic [TIME_BITS-1:0] key,
  input  logic [7:0]           key_owner,
  input  logic                 left_le,
  input  logic                 found_in,
  input  logic [TIME_BITS-1:0] left_deadline,
  input  logic [7:0]           left_owner,
  input  logic [TIME_BITS-1:0] right_deadline,
  input  logic [7:0]           right_owner,
  output logic [TIME_BITS-1:0] cell_deadline,
  output logic [7:0]           cell_owner,
  output stq_pkg::cell_stat_t  stat
);
  import stq_pkg::*;

  logic le, ge, match, first;

  assign le    = entry_valid && (cell_deadline <= key);
  assign ge    = entry_valid && (cell_deadline >= key);
  assign match = entry_valid && (cell_owner == key_owner);
  assign first = match && !found_in;

  assign stat.le    = le;
  assign stat.found = found_in || match;
  assign stat.kept  = first && (((ctrl.keep_mode == KM_EARLIEST) && le) ||
                                ((ctrl.keep_mode == KM_LATEST) && ge));

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_POP: begin
        cell_deadline <= right_deadline;
        cell_owner    <= right_owner;
      end
      OP_REMOVE: begin
        if (stat.found) begin
          cell_deadline <= right_deadline;
          cell_owner    <= right_owner;
        end
      end
      OP_INSERT: begin
        if (!le) begin
          if (left_le) begin
            cell_deadline <= key;
            cell_owner    <= key_owner;
          end else begin
            cell_deadline <= left_deadline;
            cell_owner    <= left_owner;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/stq_checker.sv @@
// ---------------------------------------------------------------------------
// stq_checker: port-level checks of the sorted timer queue
// Watches request transfers and result strobes on the top level.
// ---------------------------------------------------------------------------
module stq_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        valid,
  input logic [2:0]  status,
  input logic [7:0]  fired_owner,
  input logic [31:0] fired_deadline,
  input logic        last
);
  import stq_pkg::*;

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request transfer did not raise busy");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> !busy) else $error("final result while still busy");

  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> busy) else $error("result without last but block idle");

  a_single: assert property (@(posedge clk) disable iff (rst)
    valid && status != ST_FIRED |-> last && fired_owner == '0 && fired_deadline == '0)
    else $error("non-fired result not single or carries data");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> !valid) else $error("result without a request");

endmodule

bind sorted_timer_queue_top stq_checker u_stq_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .valid         (valid),
  .status        (status),
  .fired_owner   (fired_owner),
  .fired_deadline(fired_deadline),
  .last          (last)
);

@@ tb/sv/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: self-checking bench for sorted_timer_queue_top
// Drives register and tick requests, predicts every result with a local
// sorted queue model and compares each result field by field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import stq_pkg::*;

  localparam int Depth   = 16;
  localparam int IdleCap = 20000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        func;
  logic [31:0] deadline;
  logic [1:0]  time_mode;
  logic [1:0]  keep_mode;
  logic [7:0]  owner_id;
  logic [31:0] now;
  logic        valid;
  logic [2:0]  status;
  logic [7:0]  fired_owner;
  logic [31:0] fired_deadline;
  logic        last;

  // One expected result: status, owner, deadline and last flag.
  typedef struct packed {
    logic [2:0]  st;
    logic [7:0]  own;
    logic [31:0] dl;
    logic        lst;
  } timer_result_t;

  // The predicted contents of the timer queue, sorted by deadline.
  logic [31:0]   q_deadline[Depth];
  logic [7:0]    q_owner[Depth];
  int            q_count;
  timer_result_t pending_results[$];
  int            mismatches;
  int            idle_cycles;
  int            fired_seen;
  int            items_sent;

  sorted_timer_queue_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .deadline(deadline), .time_mode(time_mode), .keep_mode(keep_mode),
    .owner_id(owner_id), .now(now), .valid(valid), .status(status),
    .fired_owner(fired_owner), .fired_deadline(fired_deadline), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Remove the entry at a position, closing the gap behind it.
  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < q_count; i++) begin
      q_deadline[i] = q_deadline[i + 1];
      q_owner[i]    = q_owner[i + 1];
    end
    q_count--;
  endfunction

  // Predict the status of a register request and update the queue.
  function automatic logic [2:0] predict_register(input logic [31:0] dl_in,
      input logic [1:0] tm, input logic [1:0] km, input logic [7:0] own,
      input logic [31:0] t_now);
    logic [32:0] sum;
    logic [31:0] dl;
    int          pos;
    dl = dl_in;
    if (tm == TM_RELATIVE) begin
      sum = {1'b0, t_now} + {1'b0, dl_in};
      dl  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end else if (tm != TM_ABSOLUTE) begin
      return ST_BAD_TIME;
    end
    if (km == KM_INVALID) return ST_BAD_KEEP;
    if (km != KM_NONE) begin
      for (int i = 0; i < q_count; i++) begin
        if (q_owner[i] == own) begin
          if (km == KM_EARLIEST && q_deadline[i] <= dl) return ST_KEPT;
          if (km == KM_LATEST && q_deadline[i] >= dl) return ST_KEPT;
          drop_entry(i);
          break;
        end
      end
    end
    if (q_count >= Depth) return ST_FULL;
    pos = 0;
    while (pos < q_count && q_deadline[pos] <= dl) pos++;
    for (int i = q_count; i > pos; i--) begin
      q_deadline[i] = q_deadline[i - 1];
      q_owner[i]    = q_owner[i - 1];
    end
    q_deadline[pos] = dl;
    q_owner[pos]    = own;
    q_count++;
    return ST_INSERTED;
  endfunction

  // Predict the fired entries of a tick and queue them as expectations.
  task automatic predict_tick(input logic [31:0] t_now);
    int            n;
    timer_result_t r;
    n = 0;
    while (n < MaxResults && q_count > 0 && q_deadline[0] <= t_now) begin
      r = timer_result_t'{ST_FIRED, q_owner[0], q_deadline[0], 1'b0};
      pending_results.push_back(r);
      drop_entry(0);
      n++;
    end
    if (n == 0) begin
      pending_results.push_back(timer_result_t'{ST_NONE, 8'd0, 32'd0, 1'b1});
    end else begin
      r = pending_results.pop_back();
      r.lst = 1'b1;
      pending_results.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Send one request. Start stays high across back-to-back transfers; the
  // expectation is recorded at the accepting edge so it precedes results.
  task automatic send_request(input logic f, input logic [31:0] dl,
      input logic [1:0] tm, input logic [1:0] km, input logic [7:0] own,
      input logic [31:0] t_now, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    func      <= f;
    deadline  <= dl;
    time_mode <= tm;
    keep_mode <= km;
    owner_id  <= own;
    now       <= t_now;
    do @(posedge clk); while (busy);
    if (f == FUNC_REGISTER)
      pending_results.push_back(timer_result_t'{
          predict_register(dl, tm, km, own, t_now), 8'd0, 32'd0, 1'b1});
    else
      predict_tick(t_now);
    items_sent++;
  endtask

  function automatic int random_gap();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 0;
    if (sel < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker: compares every strobed result with the oldest expectation.
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst && valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result status", 32'(status), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (status != want.st)
          report_mismatch("status", 32'(status), 32'(want.st));
        if (fired_owner != want.own)
          report_mismatch("fired_owner", 32'(fired_owner), 32'(want.own));
        if (fired_deadline != want.dl)
          report_mismatch("fired_deadline", fired_deadline, want.dl);
        if (last != want.lst)
          report_mismatch("last", 32'(last), 32'(want.lst));
        if (status == ST_FIRED) fired_seen++;
      end
    end
  end

  // Watchdog: counts cycles in which neither side makes a transfer.
  always @(posedge clk) begin
    if (rst || valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleCap) begin
        $display("watchdog expired at %0t", $time);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Mode checks: every invalid time mode and keep mode, and the wide
  // relative deadline that must saturate at the largest time value.
  task automatic test_modes();
    send_request(FUNC_REGISTER, 32'h0, 2'd0, KM_NONE, 8'h00, 32'h0, 0);
    send_request(FUNC_REGISTER, 32'hFFFF_FFFF, 2'd3, KM_EARLIEST, 8'hFF,
                 32'hFFFF_FFFF, 0);
    send_request(FUNC_REGISTER, 32'd5, TM_ABSOLUTE, KM_INVALID, 8'h11, 32'd0, 0);
    send_request(FUNC_REGISTER, 32'hFFFF_FFF0, TM_RELATIVE, KM_NONE, 8'hAA,
                 32'h0000_0100, 1);
    send_request(FUNC_REGISTER, 32'hFFFF_FFFF, TM_ABSOLUTE, KM_NONE, 8'h55,
                 32'd0, 0);
    send_request(FUNC_REGISTER, 32'd7, TM_ABSOLUTE, KM_INVALID, 8'h55, 32'd0, 0);
    send_request(FUNC_TICK, 32'h0, 2'd0, KM_NONE, 8'h00, 32'hFFFF_FFFE, 2);
    send_request(FUNC_TICK, 32'hFFFF_FFFF, 2'd3, KM_INVALID, 8'hFF,
                 32'hFFFF_FFFF, 0);
    send_request(FUNC_TICK, 32'h0, 2'd0, KM_NONE, 8'h00, 32'hFFFF_FFFF, 0);
  endtask

  // Keep policies on both sides of the comparison, ties included.
  task automatic test_keep_policies();
    send_request(FUNC_REGISTER, 32'd100, TM_ABSOLUTE, KM_NONE, 8'h01, 32'd0, 0);
    send_request(FUNC_REGISTER, 32'd100, TM_ABSOLUTE, KM_EARLIEST, 8'h01, 32'd0, 0);
    send_request(FUNC_REGISTER, 32'd50, TM_ABSOLUTE, KM_EARLIEST, 8'h01, 32'd0, 0);
    send_request(FUNC_REGISTER, 32'd40, TM_ABSOLUTE, KM_LATEST, 8'h01, 32'd0, 1);
    send_request(FUNC_REGISTER, 32'd90, TM_RELATIVE, KM_LATEST, 8'h01, 32'd10, 0);
    send_request(FUNC_REGISTER, 32'd100, TM_ABSOLUTE, KM_NONE, 8'h01, 32'd0, 0);
    send_request(FUNC_REGISTER, 32'd100, TM_ABSOLUTE, KM_NONE, 8'h02, 32'd0, 0);
    send_request(FUNC_TICK, 32'd0, 2'd0, KM_NONE, 8'h00, 32'd100, 0);
  endtask

  // Fill the queue past its depth, then one tick fires all sixteen entries.
  task automatic test_full_queue();
    for (int i = 0; i < Depth + 2; i++)
      send_request(FUNC_REGISTER, 32'(Depth - i), TM_ABSOLUTE, KM_NONE,
                   8'(i), 32'd0, 0);
    send_request(FUNC_TICK, 32'd0, 2'd0, KM_NONE, 8'h00, 32'hFFFF_FFFF, 0);
    drain_results();
  endtask

  // Random traffic: mostly well-formed registrations with a small owner set
  // and nearby deadlines, ticks that advance time, plus invalid mode noise.
  task automatic test_random_traffic(input int count);
    logic [31:0] t_now;
    logic [31:0] dl;
    logic [1:0]  tm;
    logic [1:0]  km;
    int          sel;
    t_now = $urandom_range(0, 1000);
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (k == count / 2) drain_results();
      if (sel < 25) begin
        t_now = t_now + $urandom_range(0, 60);
        send_request(FUNC_TICK, $urandom, 2'($urandom), 2'($urandom),
                     8'($urandom), t_now, random_gap());
      end else begin
        tm = (sel < 90) ? ($urandom_range(0, 1) ? TM_ABSOLUTE : TM_RELATIVE)
                        : 2'($urandom);
        km = (sel < 95) ? 2'($urandom_range(0, 2)) : KM_INVALID;
        dl = (tm == TM_ABSOLUTE) ? t_now + $urandom_range(0, 80)
                                 : 32'($urandom_range(0, 80));
        if (sel > 97) dl = $urandom;
        send_request(FUNC_REGISTER, dl, tm, km, 8'($urandom_range(0, 7)), t_now,
                     random_gap());
      end
    end
    send_request(FUNC_TICK, 32'd0, 2'd0, KM_NONE, 8'h00, 32'hFFFF_FFFF, 0);
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    func        = FUNC_REGISTER;
    deadline    = '0;
    time_mode   = TM_ABSOLUTE;
    keep_mode   = KM_NONE;
    owner_id    = '0;
    now         = '0;
    q_count     = 0;
    mismatches  = 0;
    idle_cycles = 0;
    fired_seen  = 0;
    items_sent  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_modes();
    test_keep_policies();
    test_full_queue();
    test_random_traffic(75);

    drain_results();
    repeat (40) @(posedge clk);
    $display("covered %0d requests: invalid modes, keep policies, full queue,",
             items_sent);
    $display("saturating deadlines and %0d fired entries", fired_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
